FILE: hw/rtl/pmtp_pkg.sv
package pmtp_pkg;

    // Default limit on elementary stream entries per section
    localparam int unsigned MAX_STREAMS_DEF = 128;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Field masks
    localparam logic [7:0] PID_HI_MASK = 8'h1F;
    localparam logic [7:0] LEN_HI_MASK = 8'h0F;

    // Result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Parse phases
    typedef enum logic [3:0] {
        PH_PCR_HI = 4'd0,
        PH_PCR_LO = 4'd1,
        PH_PIL_HI = 4'd2,
        PH_PIL_LO = 4'd3,
        PH_PSKIP  = 4'd4,
        PH_TYPE   = 4'd5,
        PH_PID_HI = 4'd6,
        PH_PID_LO = 4'd7,
        PH_LEN_HI = 4'd8,
        PH_LEN_LO = 4'd9,
        PH_ESKIP  = 4'd10,
        PH_IGNORE = 4'd11
    } t_phase;

    // One queued record: an entry result, a summary result, or both
    typedef struct packed {
        logic        has_entry;
        logic        has_summary;
        logic [7:0]  es_type;
        logic [12:0] elem_pid;
        logic [11:0] es_info_length;
        logic [12:0] pcr_pid;
        logic [11:0] program_info_length;
        logic [7:0]  stream_count;
        logic        too_many_streams;
        logic        short_section;
    } t_rec;

endpackage

FILE: hw/rtl/pmtp_ifs.sv
interface pmtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       final_byte;

    modport source (output valid, output body_byte, output final_byte, input ready);
    modport sink   (input valid, input body_byte, input final_byte, output ready);
endinterface

interface pmtp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  es_type;
    logic [12:0] elem_pid;
    logic [11:0] es_info_length;
    logic [12:0] pcr_pid;
    logic [11:0] program_info_length;
    logic [7:0]  stream_count;
    logic        too_many_streams;
    logic        short_section;
    logic        last_result;

    modport source (
        output valid, output result_kind, output es_type, output elem_pid,
        output es_info_length, output pcr_pid, output program_info_length,
        output stream_count, output too_many_streams, output short_section,
        output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input es_type, input elem_pid,
        input es_info_length, input pcr_pid, input program_info_length,
        input stream_count, input too_many_streams, input short_section,
        input last_result, output ready
    );
endinterface

FILE: hw/rtl/pmt_section_body_parser_unit.sv
// Program map section body parser.
// i_in carries the section body, one byte per item, from the byte after the
// 8-byte header up to the CRC; final_byte marks the last body byte.
// o_out carries results: one stream entry result per completed 5-byte entry
// and one section summary on the final byte (after the entry when both fall
// on that byte). last_result marks the final result caused by one byte.
// Throughput: one body byte per cycle while the queue has room. The front
// parser updates its phase per byte and puts records in a two-entry queue;
// the back end shows one result per cycle from its output register while
// the receiver is ready; a byte that completes an entry and ends the section
// gives two results. Results pass the queue, then the output register.
// When the receiver stalls, results wait in the output register and queue,
// and i_in.ready drops only when the queue is full.
// Reset (synchronous, i_rst_n low) clears the parse state to the start of a
// section and empties the queue; the state also returns to the start of a
// section after every final byte.
module pmt_section_body_parser_unit #(
    parameter int unsigned MAX_STREAMS = pmtp_pkg::MAX_STREAMS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmtp_byte_if.sink     i_in,
    pmtp_result_if.source o_out
);

    logic           push;
    logic           pop;
    logic           full;
    logic           avail;
    pmtp_pkg::t_rec push_rec;
    pmtp_pkg::t_rec head_rec;

    pmtp_front #(
        .MAX_STREAMS(MAX_STREAMS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    pmtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_rec   (head_rec)
    );

    pmtp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_rec   (head_rec),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: hw/rtl/pmtp_front.sv
module pmtp_front #(
    parameter int unsigned MAX_STREAMS = pmtp_pkg::MAX_STREAMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmtp_byte_if.sink         i_in,
    input  logic              i_full,
    output logic              o_push,
    output pmtp_pkg::t_rec    o_rec
);

    localparam logic [7:0] MaxCount = 8'(MAX_STREAMS);

    pmtp_pkg::t_phase r_phase, n_phase;
    logic [11:0] r_skip, n_skip;
    logic [12:0] r_pcr, n_pcr;
    logic [11:0] r_pil, n_pil;
    logic [7:0]  r_etype, n_etype;
    logic [12:0] r_epid, n_epid;
    logic [3:0]  r_elen_hi, n_elen_hi;
    logic [7:0]  r_count, n_count;
    logic        r_ovf, n_ovf;

    logic        accept;
    logic        entry_done;
    logic        is_short;
    logic [7:0]  b;
    logic [11:0] len;
    logic [11:0] skip_dec;

    // Accept a byte whenever the queue has room
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.body_byte;
    assign len        = {r_elen_hi, b};
    assign skip_dec   = r_skip - 12'd1;

    // Advance the parse phase for one byte
    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_pcr      = r_pcr;
        n_pil      = r_pil;
        n_etype    = r_etype;
        n_epid     = r_epid;
        n_elen_hi  = r_elen_hi;
        n_count    = r_count;
        n_ovf      = r_ovf;
        entry_done = 1'b0;
        unique case (r_phase)
            pmtp_pkg::PH_PCR_HI: begin
                n_pcr   = {b[4:0] & pmtp_pkg::PID_HI_MASK[4:0], 8'h00};
                n_phase = pmtp_pkg::PH_PCR_LO;
            end
            pmtp_pkg::PH_PCR_LO: begin
                n_pcr   = {r_pcr[12:8], b};
                n_phase = pmtp_pkg::PH_PIL_HI;
            end
            pmtp_pkg::PH_PIL_HI: begin
                n_pil   = {b[3:0] & pmtp_pkg::LEN_HI_MASK[3:0], 8'h00};
                n_phase = pmtp_pkg::PH_PIL_LO;
            end
            pmtp_pkg::PH_PIL_LO: begin
                n_pil   = {r_pil[11:8], b};
                n_skip  = {r_pil[11:8], b};
                n_phase = ({r_pil[11:8], b} == 12'd0) ? pmtp_pkg::PH_TYPE
                                                      : pmtp_pkg::PH_PSKIP;
            end
            pmtp_pkg::PH_PSKIP, pmtp_pkg::PH_ESKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 12'd0) begin
                    n_phase = pmtp_pkg::PH_TYPE;
                end
            end
            pmtp_pkg::PH_TYPE: begin
                if (r_count >= MaxCount) begin
                    n_ovf   = 1'b1;
                    n_phase = pmtp_pkg::PH_IGNORE;
                end else begin
                    n_etype = b;
                    n_phase = pmtp_pkg::PH_PID_HI;
                end
            end
            pmtp_pkg::PH_PID_HI: begin
                n_epid  = {b[4:0] & pmtp_pkg::PID_HI_MASK[4:0], 8'h00};
                n_phase = pmtp_pkg::PH_PID_LO;
            end
            pmtp_pkg::PH_PID_LO: begin
                n_epid  = {r_epid[12:8], b};
                n_phase = pmtp_pkg::PH_LEN_HI;
            end
            pmtp_pkg::PH_LEN_HI: begin
                n_elen_hi = b[3:0] & pmtp_pkg::LEN_HI_MASK[3:0];
                n_phase   = pmtp_pkg::PH_LEN_LO;
            end
            pmtp_pkg::PH_LEN_LO: begin
                entry_done = 1'b1;
                n_count    = r_count + 8'd1;
                n_skip     = len;
                n_phase    = (len == 12'd0) ? pmtp_pkg::PH_TYPE : pmtp_pkg::PH_ESKIP;
            end
            default: begin
            end
        endcase
    end

    // Flag a section that ends inside a field or a skip
    assign is_short = !(n_phase == pmtp_pkg::PH_TYPE || n_phase >= pmtp_pkg::PH_IGNORE);

    // Build the record for the queue
    always_comb begin
        o_rec = '0;
        o_rec.has_entry   = entry_done;
        o_rec.has_summary = i_in.final_byte;
        if (entry_done) begin
            o_rec.es_type        = r_etype;
            o_rec.elem_pid       = r_epid;
            o_rec.es_info_length = len;
        end
        if (i_in.final_byte) begin
            o_rec.pcr_pid             = n_pcr;
            o_rec.program_info_length = n_pil;
            o_rec.stream_count        = n_count;
            o_rec.too_many_streams    = n_ovf;
            o_rec.short_section       = is_short;
        end
    end

    assign o_push = accept && (entry_done || i_in.final_byte);

    // Hold parse state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.final_byte)) begin
            r_phase   <= pmtp_pkg::PH_PCR_HI;
            r_skip    <= '0;
            r_pcr     <= '0;
            r_pil     <= '0;
            r_etype   <= '0;
            r_epid    <= '0;
            r_elen_hi <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_pcr     <= n_pcr;
            r_pil     <= n_pil;
            r_etype   <= n_etype;
            r_epid    <= n_epid;
            r_elen_hi <= n_elen_hi;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
        end
    end

endmodule

FILE: hw/rtl/pmtp_queue.sv
module pmtp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pmtp_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_avail,
    output pmtp_pkg::t_rec o_rec
);

    pmtp_pkg::t_rec r_mem [pmtp_pkg::QUEUE_DEPTH];
    logic [pmtp_pkg::QUEUE_AW-1:0] r_wr;
    logic [pmtp_pkg::QUEUE_AW-1:0] r_rd;
    logic [pmtp_pkg::QUEUE_CW-1:0] r_cnt;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == pmtp_pkg::QUEUE_CW'(pmtp_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    // Store records
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == pmtp_pkg::QUEUE_AW'(pmtp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == pmtp_pkg::QUEUE_AW'(pmtp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/pmtp_back.sv
module pmtp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  pmtp_pkg::t_rec i_rec,
    output logic           o_pop,
    pmtp_result_if.source  o_out
);

    pmtp_pkg::t_rec r_cur;
    logic r_valid;
    logic r_sum_step;
    logic show_entry;
    logic taken;
    logic done;

    // Emit the entry first, then the summary of the same record
    assign show_entry = r_cur.has_entry && !r_sum_step;
    assign taken      = r_valid && o_out.ready;
    assign done       = taken && !(show_entry && r_cur.has_summary);
    assign o_pop      = i_avail && (!r_valid || done);

    // Load the next record or step to its summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sum_step <= 1'b0;
        end else if (!r_valid || done) begin
            r_valid    <= i_avail;
            r_sum_step <= 1'b0;
        end else if (taken) begin
            r_sum_step <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_rec;
        end
    end

    // Drive the result fields from the held record
    always_comb begin
        o_out.valid               = r_valid;
        o_out.result_kind         = show_entry ? pmtp_pkg::KIND_ENTRY : pmtp_pkg::KIND_SUMMARY;
        o_out.es_type             = show_entry ? r_cur.es_type : '0;
        o_out.elem_pid            = show_entry ? r_cur.elem_pid : '0;
        o_out.es_info_length      = show_entry ? r_cur.es_info_length : '0;
        o_out.pcr_pid             = show_entry ? '0 : r_cur.pcr_pid;
        o_out.program_info_length = show_entry ? '0 : r_cur.program_info_length;
        o_out.stream_count        = show_entry ? '0 : r_cur.stream_count;
        o_out.too_many_streams    = show_entry ? 1'b0 : r_cur.too_many_streams;
        o_out.short_section       = show_entry ? 1'b0 : r_cur.short_section;
        o_out.last_result         = show_entry ? !r_cur.has_summary : 1'b1;
    end

endmodule
